### rtl/core/tlv_header_parser_core_defines.svh
// ----------------------------------------------------------------------------
// TLV header parser assertion macros
// Concurrent assertion wrappers clocked on clk; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TLV_HEADER_PARSER_CORE_DEFINES_SVH
`define TLV_HEADER_PARSER_CORE_DEFINES_SVH

`ifndef SYNTH
// check a property outside reset
`define TLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property at every edge, reset included
`define TLV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLV_ASSERT(lbl, prop, msg)
`define TLV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/tlv_pkg.sv
// ----------------------------------------------------------------------------
// TLV header parser package
// Shared types, status codes and constants for the BER-TLV header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tlv_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TAG2,
    PH_LEN1,
    PH_LENX
  } tlv_phase_t;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_ARG = 3'd1;
  localparam logic [2:0] ST_BAD_TAG = 3'd2;
  localparam logic [2:0] ST_BAD_LEN = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // encoding constants
  localparam logic [4:0] TAG_MULTI_BYTE = 5'h1F;
  localparam logic [6:0] LEN_MAX_EXTRA  = 7'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [15:0] buffer_len;
  } tlv_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tag_number;
    logic [1:0]  tag_length;
    logic [1:0]  length_length;
    logic [15:0] value_length;
    logic [2:0]  value_offset;
    logic [16:0] object_length;
    logic [1:0]  tag_class;
    logic        constructed;
  } tlv_result_t;

endpackage

`default_nettype wire

### rtl/core/tlv_header_parser_core.sv
// A result is valid in the cycle after the byte that completes or fails the header.
// One byte per cycle unless stalled; the header state updates in a single registered pass.
// A result held in the output register stalls input only while it is not taken.
// Reset (rst, synchronous): parser returns to idle, output register empties.
// ----------------------------------------------------------------------------
// TLV header parser core
// Decodes BER-TLV tag and length fields from a byte stream, at most one result per buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tlv_header_parser_core_defines.svh"

module tlv_header_parser_core
  import tlv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire tlv_item_t   item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output tlv_result_t      result
);

  tlv_phase_t  phase, phase_next;
  logic [7:0]  first_tag_byte, first_tag_byte_next;
  logic [15:0] tag_accum, tag_accum_next;
  logic [1:0]  length_bytes_left, length_bytes_left_next;
  logic [15:0] length_accum, length_accum_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [15:0] saved_buffer_len, saved_buffer_len_next;
  logic [1:0]  len_field_size, len_field_size_next;

  logic        item_fire;
  logic        active;
  logic        done;
  logic        err;
  logic [2:0]  err_code;
  logic        emit;
  logic        overrun;
  logic [1:0]  tag_len;
  tlv_result_t result_next;

  // accept while the result register is free or being drained
  assign item_ready = !result_valid || result_ready;
  assign item_fire  = item_valid && item_ready;

  // next header state and result for the current byte
  always_comb begin
    phase_next             = phase;
    first_tag_byte_next    = first_tag_byte;
    tag_accum_next         = tag_accum;
    length_bytes_left_next = length_bytes_left;
    length_accum_next      = length_accum;
    byte_position_next     = byte_position;
    saved_buffer_len_next  = saved_buffer_len;
    len_field_size_next    = len_field_size;
    active                 = 1'b1;
    done                   = 1'b0;
    err                    = 1'b0;
    err_code               = ST_OK;

    if (item.start_req) begin
      saved_buffer_len_next  = item.buffer_len;
      byte_position_next     = 3'd0;
      length_accum_next      = 16'd0;
      length_bytes_left_next = 2'd0;
      len_field_size_next    = 2'd0;
      tag_accum_next         = 16'd0;
      first_tag_byte_next    = 8'd0;
      if (item.buffer_len == 16'd0) begin
        err      = 1'b1;
        err_code = ST_BAD_ARG;
      end else begin
        first_tag_byte_next = item.data_byte;
        byte_position_next  = 3'd1;
        if (item.data_byte[4:0] == TAG_MULTI_BYTE) begin
          phase_next = PH_TAG2;
        end else begin
          tag_accum_next = {8'd0, item.data_byte};
          phase_next     = PH_LEN1;
        end
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          active = 1'b0;
        end
        PH_TAG2: begin
          byte_position_next = byte_position + 3'd1;
          if (item.data_byte[7]) begin
            err      = 1'b1;
            err_code = ST_BAD_TAG;
          end else begin
            tag_accum_next = {first_tag_byte, 1'b0, item.data_byte[6:0]};
            phase_next     = PH_LEN1;
          end
        end
        PH_LEN1: begin
          byte_position_next = byte_position + 3'd1;
          if (item.data_byte[7]) begin
            if (item.data_byte[6:0] > LEN_MAX_EXTRA) begin
              err      = 1'b1;
              err_code = ST_BAD_LEN;
            end else begin
              len_field_size_next = item.data_byte[1:0] + 2'd1;
              length_accum_next   = 16'd0;
              if (item.data_byte[1:0] == 2'd0) begin
                done = 1'b1;
              end else begin
                length_bytes_left_next = item.data_byte[1:0];
                phase_next             = PH_LENX;
              end
            end
          end else begin
            length_accum_next   = {9'd0, item.data_byte[6:0]};
            len_field_size_next = 2'd1;
            done                = 1'b1;
          end
        end
        PH_LENX: begin
          byte_position_next     = byte_position + 3'd1;
          length_accum_next      = {length_accum[7:0], item.data_byte};
          length_bytes_left_next = length_bytes_left - 2'd1;
          if (length_bytes_left_next == 2'd0) begin
            done = 1'b1;
          end
        end
        default: begin
          active = 1'b0;
        end
      endcase
    end

    // value must fit in the buffer after the header
    overrun = (length_accum_next != 16'd0) &&
              (({14'd0, byte_position_next} + {1'b0, length_accum_next}) >
               {1'b0, saved_buffer_len_next});
    tag_len = (first_tag_byte_next[4:0] == TAG_MULTI_BYTE) ? 2'd2 : 2'd1;

    priority if (err) begin
      // error code already chosen
    end else if (done) begin
      if (overrun) begin
        err      = 1'b1;
        err_code = ST_BAD_LEN;
      end
    end else if (active && ({13'd0, byte_position_next} >= saved_buffer_len_next)) begin
      err      = 1'b1;
      err_code = ST_TRUNC;
    end else begin
      // header still in progress, or idle: nothing to report
    end

    emit = err || done;
    if (emit) begin
      phase_next = PH_IDLE;
    end

    // assemble the result transaction
    result_next = '0;
    if (err) begin
      result_next.status = err_code;
    end else begin
      result_next.status        = ST_OK;
      result_next.tag_number    = tag_accum_next;
      result_next.tag_length    = tag_len;
      result_next.length_length = len_field_size_next;
      result_next.value_length  = length_accum_next;
      result_next.value_offset  = (length_accum_next != 16'd0) ? byte_position_next : 3'd0;
      result_next.object_length = {15'd0, tag_len} + {15'd0, len_field_size_next} +
                                  {1'b0, length_accum_next};
      result_next.tag_class     = first_tag_byte_next[7:6];
      result_next.constructed   = first_tag_byte_next[5];
    end
  end

  // header state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      first_tag_byte    <= 8'd0;
      tag_accum         <= 16'd0;
      length_bytes_left <= 2'd0;
      length_accum      <= 16'd0;
      byte_position     <= 3'd0;
      saved_buffer_len  <= 16'd0;
      len_field_size    <= 2'd0;
    end else if (item_fire) begin
      phase             <= phase_next;
      first_tag_byte    <= first_tag_byte_next;
      tag_accum         <= tag_accum_next;
      length_bytes_left <= length_bytes_left_next;
      length_accum      <= length_accum_next;
      byte_position     <= byte_position_next;
      saved_buffer_len  <= saved_buffer_len_next;
      len_field_size    <= len_field_size_next;
    end
  end

  // result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_fire && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && emit) begin
      result <= result_next;
    end
  end

  // checks
  `TLV_ASSERT(a_stall_blocks_input,
              (result_valid && !result_ready) |-> !item_ready,
              "input accepted while result stalled")
  `TLV_ASSERT(a_error_fields_zero,
              (result_valid && result.status != ST_OK) |->
                (result.tag_length == 2'd0 && result.object_length == 17'd0),
              "error result carries nonzero fields")
  `TLV_ASSERT(a_object_sum,
              (result_valid && result.status == ST_OK) |->
                (result.object_length == {15'd0, result.tag_length} +
                 {15'd0, result.length_length} + {1'b0, result.value_length}),
              "object length mismatch")
  `TLV_ASSERT(a_zero_len_start,
              (item_fire && item.start_req && item.buffer_len == 16'd0) |=>
                (result_valid && result.status == ST_BAD_ARG && phase == PH_IDLE),
              "zero buffer length not flagged")
  `TLV_ASSERT_ALWAYS(a_reset_empties, rst |=> !result_valid, "result valid after reset")

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV header parser testbench
// Feeds byte streams of well-formed and broken BER-TLV headers plus noise,
// with random gaps on both channels, and checks every decoded header against
// a cycle-free predictor of the parser.
// ----------------------------------------------------------------------------
module testbench;
  import tlv_pkg::*;

  // Header predictor and store of expected decode results
  class tlv_header_checker;
    tlv_phase_t  phase;
    logic [7:0]  first_tag;
    logic [15:0] tag_accum;
    logic [1:0]  len_bytes_left;
    logic [15:0] len_accum;
    logic [2:0]  byte_pos;
    logic [15:0] buf_len;
    logic [1:0]  len_field_size;
    tlv_result_t expected_headers[$];
    int          fails;

    function new();
      phase          = PH_IDLE;
      first_tag      = '0;
      tag_accum      = '0;
      len_bytes_left = '0;
      len_accum      = '0;
      byte_pos       = '0;
      buf_len        = '0;
      len_field_size = '0;
      fails          = 0;
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction

    // queue an error result and fall back to idle
    function void push_fault(logic [2:0] code);
      tlv_result_t r;
      r        = '0;
      r.status = code;
      expected_headers.push_back(r);
      phase = PH_IDLE;
    endfunction

    // header complete: check for value overrun, then build the result
    function void push_header();
      tlv_result_t r;
      int          tlen;
      int          vlen;
      tlen = (first_tag[4:0] == TAG_MULTI_BYTE) ? 2 : 1;
      vlen = len_accum;
      if (vlen != 0 && int'(byte_pos) + vlen > int'(buf_len)) begin
        push_fault(ST_BAD_LEN);
        return;
      end
      r               = '0;
      r.status        = ST_OK;
      r.tag_number    = tag_accum;
      r.tag_length    = 2'(tlen);
      r.length_length = len_field_size;
      r.value_length  = len_accum;
      r.value_offset  = (vlen != 0) ? byte_pos : 3'd0;
      r.object_length = 17'(tlen + int'(len_field_size) + vlen);
      r.tag_class     = first_tag[7:6];
      r.constructed   = first_tag[5];
      expected_headers.push_back(r);
      phase = PH_IDLE;
    endfunction

    // advance the parser state by one accepted transaction
    function void note_byte(tlv_item_t it);
      logic [7:0] b;
      logic [6:0] n;
      bit         done;
      b    = it.data_byte;
      done = 0;
      if (it.start_req) begin
        buf_len        = it.buffer_len;
        byte_pos       = '0;
        len_accum      = '0;
        len_bytes_left = '0;
        len_field_size = '0;
        tag_accum      = '0;
        first_tag      = '0;
        if (buf_len == 0) begin
          push_fault(ST_BAD_ARG);
          return;
        end
        first_tag = b;
        byte_pos  = 3'd1;
        if (b[4:0] == TAG_MULTI_BYTE) begin
          phase = PH_TAG2;
        end else begin
          tag_accum = {8'h00, b};
          phase     = PH_LEN1;
        end
      end else begin
        if (phase == PH_IDLE) return;
        byte_pos = byte_pos + 3'd1;
        case (phase)
          PH_TAG2: begin
            if (b[7]) begin
              push_fault(ST_BAD_TAG);
              return;
            end
            tag_accum = {first_tag, 1'b0, b[6:0]};
            phase     = PH_LEN1;
          end
          PH_LEN1: begin
            if (b[7]) begin
              n = b[6:0];
              if (n > LEN_MAX_EXTRA) begin
                push_fault(ST_BAD_LEN);
                return;
              end
              len_field_size = 2'(n + 7'd1);
              len_accum      = '0;
              if (n == 0) begin
                done = 1;
              end else begin
                len_bytes_left = n[1:0];
                phase          = PH_LENX;
              end
            end else begin
              len_accum      = {9'd0, b[6:0]};
              len_field_size = 2'd1;
              done           = 1;
            end
          end
          default: begin
            len_accum      = {len_accum[7:0], b};
            len_bytes_left = len_bytes_left - 2'd1;
            if (len_bytes_left == 0) done = 1;
          end
        endcase
      end
      if (done) begin
        push_header();
      end else if ({13'd0, byte_pos} >= buf_len) begin
        push_fault(ST_TRUNC);
      end
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        fails++;
      end
    endfunction

    // compare a decoded header against the oldest expectation
    function void check_header(tlv_result_t act);
      tlv_result_t e;
      if (expected_headers.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d",
                 $time, act.status);
        fails++;
        return;
      end
      e = expected_headers.pop_front();
      check_field("status", e.status, act.status);
      check_field("tag_number", e.tag_number, act.tag_number);
      check_field("tag_length", e.tag_length, act.tag_length);
      check_field("length_length", e.length_length, act.length_length);
      check_field("value_length", e.value_length, act.value_length);
      check_field("value_offset", e.value_offset, act.value_offset);
      check_field("object_length", e.object_length, act.object_length);
      check_field("tag_class", e.tag_class, act.tag_class);
      check_field("constructed", e.constructed, act.constructed);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  tlv_item_t   item;
  logic        result_valid;
  logic        result_ready;
  tlv_result_t result;

  tlv_header_checker chk;
  bit                steady_flow;
  int                bytes_sent;

  tlv_header_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // drive one transaction after a random gap and hold it until taken
  task automatic send_byte(logic [7:0] b, logic s, logic [15:0] blen);
    tlv_item_t it;
    int        gap;
    it.data_byte  = b;
    it.start_req  = s;
    it.buffer_len = blen;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    chk.note_byte(it);
    bytes_sent++;
  endtask

  // hold the sender until every expected header has been taken
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  // build one buffer: tag, length field, then a few ignored trailing bytes
  task automatic send_buffer();
    logic [7:0]  seq[$];
    logic [7:0]  b0;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] blen;
    int          vlen;
    int          hdr;
    int          form;
    int          pick;
    int          trail;
    b0 = 8'($urandom);
    if ($urandom_range(0, 2) == 0) b0[4:0] = TAG_MULTI_BYTE;
    seq.push_back(b0);
    if (b0[4:0] == TAG_MULTI_BYTE) begin
      x = 8'($urandom);
      if ($urandom_range(0, 7) != 0) x[7] = 1'b0;
      seq.push_back(x);
    end
    form = $urandom_range(0, 9);
    vlen = 0;
    case (form)
      0, 1, 2: begin
        x = {1'b0, 7'($urandom)};
        seq.push_back(x);
        vlen = x;
      end
      3: seq.push_back(8'h80);
      4, 5: begin
        x = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        seq.push_back(8'h81);
        seq.push_back(x);
        vlen = x;
      end
      6, 7, 8: begin
        x = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        y = 8'($urandom);
        seq.push_back(8'h82);
        seq.push_back(x);
        seq.push_back(y);
        vlen = {x, y};
      end
      default: seq.push_back(8'h83 + 8'($urandom_range(0, 124)));
    endcase
    hdr  = seq.size();
    pick = $urandom_range(0, 29);
    if (pick == 0) begin
      blen = 16'd0;
    end else if (pick < 6) begin
      blen = 16'($urandom_range(1, hdr));
    end else if (pick < 16) begin
      blen = (hdr + vlen + 1 > 65535) ? 16'hFFFF
                                      : 16'(hdr + vlen + $urandom_range(0, 2) - 1);
    end else if (pick < 22) begin
      blen = 16'($urandom);
    end else begin
      blen = (hdr + vlen + 40 > 65535) ? 16'hFFFF
                                       : 16'(hdr + vlen + $urandom_range(0, 40));
    end
    // now and then cut the header short with a fresh start
    if ($urandom_range(0, 11) == 0 && hdr > 1) begin
      hdr   = $urandom_range(1, hdr - 1);
      trail = 0;
    end else begin
      trail = $urandom_range(0, 3);
    end
    send_byte(seq[0], 1'b1, blen);
    for (int k = 1; k < hdr; k++) send_byte(seq[k], 1'b0, 16'($urandom));
    for (int k = 0; k < trail; k++) send_byte(8'($urandom), 1'b0, 16'($urandom));
  endtask

  // result side: random stall before each result, then take it
  initial begin
    int stall;
    result_ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // check every taken result
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) chk.check_header(result);
  end

  initial begin
    int next_switch;
    chk         = new();
    steady_flow = 1'b0;
    bytes_sent  = 0;
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: stray byte while idle, then each header case in turn
    send_byte(8'hFF, 1'b0, 16'hFFFF);
    send_byte(8'h5A, 1'b1, 16'd0);          // zero buffer length
    send_byte(8'h5A, 1'b1, 16'd100);        // short form
    send_byte(8'h05, 1'b0, 16'd0);
    send_byte(8'h9F, 1'b1, 16'd300);        // two-byte tag, one-byte long form
    send_byte(8'h02, 1'b0, 16'd0);
    send_byte(8'h81, 1'b0, 16'd0);
    send_byte(8'h80, 1'b0, 16'd0);
    send_byte(8'hDF, 1'b1, 16'd10);         // second tag byte with bit 7 set
    send_byte(8'h80, 1'b0, 16'd0);
    send_byte(8'h70, 1'b1, 16'd10);         // three length bytes announced
    send_byte(8'h83, 1'b0, 16'd0);
    send_byte(8'h20, 1'b1, 16'd5);          // long form with no length bytes
    send_byte(8'h80, 1'b0, 16'd0);
    send_byte(8'h04, 1'b1, 16'd3);          // value runs past the buffer
    send_byte(8'h05, 1'b0, 16'd0);
    send_byte(8'h9F, 1'b1, 16'd1);          // header cut by the buffer end
    send_byte(8'h5F, 1'b1, 16'd50);         // restart in the middle of a tag
    send_byte(8'h01, 1'b1, 16'hFFFF);
    send_byte(8'h82, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte(8'h00, 1'b1, 16'hFFFF);       // value that still just fits
    send_byte(8'h82, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte(8'hFA, 1'b0, 16'd0);
    send_byte(8'hAA, 1'b0, 16'h5555);       // ignored after the result
    drain();

    // random buffers with occasional noise, gapless stretches and drains
    next_switch = bytes_sent + 80;
    while (bytes_sent < 650) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom), ($urandom_range(0, 3) == 0), 16'($urandom));
      end else begin
        send_buffer();
      end
      if (bytes_sent >= next_switch) begin
        steady_flow = ~steady_flow;
        next_switch = bytes_sent + 80;
        if ($urandom_range(0, 1) == 0) drain();
      end
    end
    drain();
    repeat (20) @(posedge clk);

    if (chk.fails == 0 && chk.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tlv_pkg.sv
rtl/core/tlv_header_parser_core.sv
bench/testbench.sv
